### src/atipd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package atipd_pkg;

   localparam int MAX_LEN_DEF = 2048;
   localparam int FRAME_LEN_W = 12;

   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_I     = 8'h49;
   localparam logic [7:0] CH_P     = 8'h50;
   localparam logic [7:0] CH_D     = 8'h44;
   localparam logic [7:0] CH_COMMA = 8'h2C;
   localparam logic [7:0] CH_COLON = 8'h3A;
   localparam logic [7:0] CH_LBRACE = 8'h7B;
   localparam logic [7:0] CH_RBRACE = 8'h7D;
   localparam logic [7:0] CH_PROMPT = 8'h3E;
   localparam logic [7:0] CH_O     = 8'h4F;
   localparam logic [7:0] CH_K     = 8'h4B;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;

   localparam logic CMD_BYTE = 1'b0;
   localparam logic CMD_ARM  = 1'b1;

   typedef enum logic [2:0] {
      HS_PLUS  = 3'd0,
      HS_I     = 3'd1,
      HS_P     = 3'd2,
      HS_D     = 3'd3,
      HS_COMMA = 3'd4,
      HS_LEN   = 3'd5,
      HS_DATA  = 3'd6
   } hstate_type;

   typedef struct packed {
      logic                   valid;
      logic                   last;
      logic [7:0]             data;
      logic [FRAME_LEN_W-1:0] frame_length;
   } payload_type;

endpackage

`default_nettype wire

### src/atipd_header.sv
`timescale 1ns / 1ps
`default_nettype none

module atipd_header #(
   parameter int MAX_LEN = atipd_pkg::MAX_LEN_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  step,
   input  wire logic [7:0]            rx_byte,
   output atipd_pkg::payload_type     result
);

   localparam int LEN_W = $clog2(MAX_LEN + 1);
   localparam int SUM_W = LEN_W + 4;
   localparam logic [SUM_W-1:0] MAX_SUM = SUM_W'(MAX_LEN);
   localparam logic [LEN_W-1:0] MAX_VAL = LEN_W'(MAX_LEN);

   atipd_pkg::hstate_type state_ff, state_in;
   logic [LEN_W-1:0] len_ff, len_in;
   logic [LEN_W-1:0] count_ff, count_in;
   logic             ended_ff, ended_in;

   logic             is_digit;
   logic [SUM_W-1:0] len_sum;
   logic [LEN_W:0]   count_inc;
   logic             at_last;
   logic [LEN_W+atipd_pkg::FRAME_LEN_W-1:0] len_wide;

   assign is_digit  = (rx_byte >= atipd_pkg::CH_ZERO) && (rx_byte <= atipd_pkg::CH_NINE);
   assign len_sum   = SUM_W'(len_ff) * SUM_W'(10)
                    + SUM_W'(rx_byte - atipd_pkg::CH_ZERO);
   assign count_inc = {1'b0, count_ff} + (LEN_W + 1)'(1);
   assign at_last   = count_inc >= {1'b0, len_ff};

   // next state and length/count datapath
   always_comb begin
      state_in = state_ff;
      len_in   = len_ff;
      count_in = count_ff;
      ended_in = ended_ff;
      if (step) begin
         case (state_ff)
            atipd_pkg::HS_I:
               state_in = (rx_byte == atipd_pkg::CH_I) ? atipd_pkg::HS_P : atipd_pkg::HS_PLUS;
            atipd_pkg::HS_P:
               state_in = (rx_byte == atipd_pkg::CH_P) ? atipd_pkg::HS_D : atipd_pkg::HS_PLUS;
            atipd_pkg::HS_D:
               state_in = (rx_byte == atipd_pkg::CH_D) ? atipd_pkg::HS_COMMA
                                                       : atipd_pkg::HS_PLUS;
            atipd_pkg::HS_COMMA: begin
               if (rx_byte == atipd_pkg::CH_COMMA) begin
                  state_in = atipd_pkg::HS_LEN;
                  len_in   = '0;
                  ended_in = 1'b0;
               end else begin
                  state_in = atipd_pkg::HS_PLUS;
               end
            end
            atipd_pkg::HS_LEN: begin
               if (rx_byte == atipd_pkg::CH_COLON) begin
                  count_in = '0;
                  state_in = (len_ff == '0) ? atipd_pkg::HS_PLUS : atipd_pkg::HS_DATA;
               end else if (!ended_ff && is_digit) begin
                  len_in = (len_sum > MAX_SUM) ? MAX_VAL : len_sum[LEN_W-1:0];
               end else begin
                  ended_in = 1'b1;
               end
            end
            atipd_pkg::HS_DATA: begin
               if (at_last) begin
                  count_in = '0;
                  state_in = atipd_pkg::HS_PLUS;
               end else begin
                  count_in = count_inc[LEN_W-1:0];
               end
            end
            default:
               state_in = (rx_byte == atipd_pkg::CH_PLUS) ? atipd_pkg::HS_I
                                                          : atipd_pkg::HS_PLUS;
         endcase
      end
   end

   assign len_wide = {{atipd_pkg::FRAME_LEN_W{1'b0}}, len_in};

   // per-byte result
   always_comb begin
      result.valid        = 1'b0;
      result.last         = 1'b0;
      result.data         = '0;
      result.frame_length = len_wide[atipd_pkg::FRAME_LEN_W-1:0];
      case (state_ff)
         atipd_pkg::HS_DATA: begin
            result.valid = step;
            result.last  = step && at_last;
            result.data  = step ? rx_byte : 8'h00;
         end
         default: begin
            result.valid = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= atipd_pkg::HS_PLUS;
         len_ff   <= '0;
         count_ff <= '0;
         ended_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         len_ff   <= len_in;
         count_ff <= count_in;
         ended_ff <= ended_in;
      end
   end

endmodule

`default_nettype wire

### src/at_response_ipd_parser_core.sv
`timescale 1ns / 1ps
`default_nettype none

// the result of an input transfer is registered in the output register and shown in the cycle after the transfer
// throughput: one byte per cycle while the output is not stalled; a new byte is taken while the held result is taken
// the output register holds one result, so req_ready drops only when it is full and stalled
// reset (synchronous, active high) returns all trackers to idle and clears the ready flag

module at_response_ipd_parser_core #(
   parameter int MAX_LEN = atipd_pkg::MAX_LEN_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic        req_command,
   input  wire logic [7:0]  req_rx_byte,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic             rsp_payload_valid,
   output logic [7:0]       rsp_payload_byte,
   output logic             rsp_payload_last,
   output logic [11:0]      rsp_frame_length,
   output logic             rsp_brace_valid,
   output logic [7:0]       rsp_brace_byte,
   output logic             rsp_brace_last,
   output logic             rsp_ready_res
);

   logic accept;
   logic step;

   atipd_pkg::payload_type payload;

   logic       brace_active_ff, brace_active_in;
   logic       ok_k_ff, ok_k_in;
   logic       ready_flag_ff, ready_flag_in;
   logic       b_valid, b_last;
   logic       brace_on;
   logic       flag_mid;

   logic       out_valid_ff;
   logic       p_valid_ff, p_last_ff, b_valid_ff, b_last_ff, r_ff;
   logic [7:0] p_byte_ff, b_byte_ff;
   logic [11:0] len_ff;

   assign req_ready = !out_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign step      = accept && (req_command == atipd_pkg::CMD_BYTE);

   atipd_header #(
      .MAX_LEN(MAX_LEN)
   ) u_header (
      .clock   (clock),
      .reset   (reset),
      .step    (step),
      .rx_byte (req_rx_byte),
      .result  (payload)
   );

   // brace capture
   assign brace_on        = brace_active_ff || (req_rx_byte == atipd_pkg::CH_LBRACE);
   assign b_valid         = step && brace_on;
   assign b_last          = b_valid && (req_rx_byte == atipd_pkg::CH_RBRACE);
   assign brace_active_in = step ? (brace_on && !b_last) : brace_active_ff;

   // ready flag and ok detector, frozen while the flag is set
   always_comb begin
      ok_k_in       = ok_k_ff;
      ready_flag_in = ready_flag_ff;
      flag_mid      = ready_flag_ff || (req_rx_byte == atipd_pkg::CH_PROMPT);
      if (accept && req_command == atipd_pkg::CMD_ARM) begin
         ready_flag_in = 1'b0;
      end else if (step) begin
         ready_flag_in = flag_mid;
         if (!flag_mid) begin
            if (!ok_k_ff) begin
               ok_k_in = (req_rx_byte == atipd_pkg::CH_O);
            end else begin
               ok_k_in       = 1'b0;
               ready_flag_in = (req_rx_byte == atipd_pkg::CH_K);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         brace_active_ff <= 1'b0;
         ok_k_ff         <= 1'b0;
         ready_flag_ff   <= 1'b0;
         out_valid_ff    <= 1'b0;
      end else begin
         brace_active_ff <= brace_active_in;
         ok_k_ff         <= ok_k_in;
         ready_flag_ff   <= ready_flag_in;
         if (accept) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         p_valid_ff <= payload.valid;
         p_last_ff  <= payload.last;
         p_byte_ff  <= payload.data;
         len_ff     <= payload.frame_length;
         b_valid_ff <= b_valid;
         b_last_ff  <= b_last;
         b_byte_ff  <= b_valid ? req_rx_byte : 8'h00;
         r_ff       <= ready_flag_in;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_payload_valid = p_valid_ff;
   assign rsp_payload_byte  = p_byte_ff;
   assign rsp_payload_last  = p_last_ff;
   assign rsp_frame_length  = len_ff;
   assign rsp_brace_valid   = b_valid_ff;
   assign rsp_brace_byte    = b_byte_ff;
   assign rsp_brace_last    = b_last_ff;
   assign rsp_ready_res     = r_ff;

endmodule

`default_nettype wire

### sim/tb_at_response_ipd_parser_core.sv
`timescale 1ns / 1ps

module tb_at_response_ipd_parser_core;

   typedef struct packed {
      logic                             payload_valid;
      logic [7:0]                       payload_byte;
      logic                             payload_last;
      logic [atipd_pkg::FRAME_LEN_W-1:0] frame_length;
      logic                             brace_valid;
      logic [7:0]                       brace_byte;
      logic                             brace_last;
      logic                             ready_res;
   } parse_result_type;

   typedef struct packed {
      logic             fixed;
      parse_result_type res;
   } typed_result_type;

   typedef struct packed {
      logic             cmd;
      logic [7:0]       chr;
      logic             fixed;
      parse_result_type res;
   } dir_row_type;

   localparam parse_result_type NO_RES    = '0;
   localparam parse_result_type IDLE_RES  = '0;
   localparam parse_result_type READY_RES = '{ready_res: 1'b1, default: '0};

   localparam int DIR_ROWS = 26;
   localparam dir_row_type DIRECTED [DIR_ROWS] = '{
      '{atipd_pkg::CMD_ARM,  8'hFF,                1'b1, IDLE_RES},
      '{atipd_pkg::CMD_BYTE, atipd_pkg::CH_PROMPT, 1'b1, READY_RES},
      '{atipd_pkg::CMD_BYTE, atipd_pkg::CH_O,      1'b1, READY_RES},  // ok tracker frozen
      '{atipd_pkg::CMD_ARM,  atipd_pkg::CH_LBRACE, 1'b1, IDLE_RES},   // arm ignores the byte
      '{atipd_pkg::CMD_BYTE, atipd_pkg::CH_O,      1'b0, NO_RES},
      '{atipd_pkg::CMD_BYTE, atipd_pkg::CH_O,      1'b0, NO_RES},     // broken ok: second o
      '{atipd_pkg::CMD_BYTE, atipd_pkg::CH_K,      1'b0, NO_RES},
      '{atipd_pkg::CMD_BYTE, atipd_pkg::CH_O,      1'b0, NO_RES},
      '{atipd_pkg::CMD_BYTE, atipd_pkg::CH_K,      1'b0, NO_RES},
      '{atipd_pkg::CMD_ARM,  8'h00,                1'b1, IDLE_RES},
      '{atipd_pkg::CMD_BYTE, atipd_pkg::CH_LBRACE, 1'b0, NO_RES},
      '{atipd_pkg::CMD_BYTE, atipd_pkg::CH_LBRACE, 1'b0, NO_RES},     // nested brace
      '{atipd_pkg::CMD_BYTE, atipd_pkg::CH_RBRACE, 1'b0, NO_RES},
      '{atipd_pkg::CMD_BYTE, atipd_pkg::CH_RBRACE, 1'b0, NO_RES},
      '{atipd_pkg::CMD_BYTE, atipd_pkg::CH_PLUS,   1'b0, NO_RES},
      '{atipd_pkg::CMD_BYTE, atipd_pkg::CH_I,      1'b0, NO_RES},
      '{atipd_pkg::CMD_BYTE, "X",                  1'b0, NO_RES},
      '{atipd_pkg::CMD_BYTE, atipd_pkg::CH_PLUS,   1'b0, NO_RES},
      '{atipd_pkg::CMD_BYTE, atipd_pkg::CH_PLUS,   1'b0, NO_RES},     // plus not re-examined
      '{atipd_pkg::CMD_BYTE, atipd_pkg::CH_PLUS,   1'b0, NO_RES},
      '{atipd_pkg::CMD_BYTE, atipd_pkg::CH_I,      1'b0, NO_RES},
      '{atipd_pkg::CMD_BYTE, atipd_pkg::CH_P,      1'b0, NO_RES},
      '{atipd_pkg::CMD_BYTE, atipd_pkg::CH_D,      1'b0, NO_RES},
      '{atipd_pkg::CMD_BYTE, atipd_pkg::CH_COMMA,  1'b0, NO_RES},
      '{atipd_pkg::CMD_BYTE, atipd_pkg::CH_ZERO,   1'b0, NO_RES},
      '{atipd_pkg::CMD_BYTE, atipd_pkg::CH_COLON,  1'b0, NO_RES}      // zero length goes idle
   };

   localparam logic [7:0] SPECIALS [8] = '{
      atipd_pkg::CH_PLUS, atipd_pkg::CH_COLON, atipd_pkg::CH_LBRACE, atipd_pkg::CH_RBRACE,
      atipd_pkg::CH_PROMPT, atipd_pkg::CH_O, atipd_pkg::CH_K, atipd_pkg::CH_COMMA
   };

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic        req_command = atipd_pkg::CMD_BYTE;
   logic [7:0]  req_rx_byte = 8'h00;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic        rsp_payload_valid;
   logic [7:0]  rsp_payload_byte;
   logic        rsp_payload_last;
   logic [11:0] rsp_frame_length;
   logic        rsp_brace_valid;
   logic [7:0]  rsp_brace_byte;
   logic        rsp_brace_last;
   logic        rsp_ready_res;

   at_response_ipd_parser_core u_top (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_command       (req_command),
      .req_rx_byte       (req_rx_byte),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_payload_valid (rsp_payload_valid),
      .rsp_payload_byte  (rsp_payload_byte),
      .rsp_payload_last  (rsp_payload_last),
      .rsp_frame_length  (rsp_frame_length),
      .rsp_brace_valid   (rsp_brace_valid),
      .rsp_brace_byte    (rsp_brace_byte),
      .rsp_brace_last    (rsp_brace_last),
      .rsp_ready_res     (rsp_ready_res)
   );

   always #5 clock = ~clock;

   // predictor state
   atipd_pkg::hstate_type             hdr_state   = atipd_pkg::HS_PLUS;
   logic [atipd_pkg::FRAME_LEN_W-1:0] len_acc     = '0;
   logic                              digits_done = 1'b0;
   logic [atipd_pkg::FRAME_LEN_W-1:0] data_count  = '0;
   logic                              brace_on    = 1'b0;
   logic                              want_k      = 1'b0;
   logic                              ready_seen  = 1'b0;

   parse_result_type expected_q [$];
   typed_result_type typed_q [$];
   int unsigned      mismatch_count = 0;
   int unsigned      items_sent = 0;
   int unsigned      tx_idle_pct = 15;
   int unsigned      rx_stall_pct = 61;

   function automatic parse_result_type advance_parser(input logic cmd, input logic [7:0] c);
      parse_result_type r;
      int unsigned      acc;
      r = '0;
      if (cmd == atipd_pkg::CMD_ARM) begin
         ready_seen = 1'b0;
      end else begin
         if (c == atipd_pkg::CH_LBRACE) brace_on = 1'b1;
         if (brace_on) begin
            r.brace_valid = 1'b1;
            r.brace_byte  = c;
            if (c == atipd_pkg::CH_RBRACE) begin
               r.brace_last = 1'b1;
               brace_on     = 1'b0;
            end
         end

         case (hdr_state)
            atipd_pkg::HS_I:
               hdr_state = (c == atipd_pkg::CH_I) ? atipd_pkg::HS_P : atipd_pkg::HS_PLUS;
            atipd_pkg::HS_P:
               hdr_state = (c == atipd_pkg::CH_P) ? atipd_pkg::HS_D : atipd_pkg::HS_PLUS;
            atipd_pkg::HS_D:
               hdr_state = (c == atipd_pkg::CH_D) ? atipd_pkg::HS_COMMA : atipd_pkg::HS_PLUS;
            atipd_pkg::HS_COMMA: begin
               if (c == atipd_pkg::CH_COMMA) begin
                  hdr_state   = atipd_pkg::HS_LEN;
                  len_acc     = '0;
                  digits_done = 1'b0;
               end else begin
                  hdr_state = atipd_pkg::HS_PLUS;
               end
            end
            atipd_pkg::HS_LEN: begin
               if (c == atipd_pkg::CH_COLON) begin
                  data_count = '0;
                  hdr_state  = (len_acc == 0) ? atipd_pkg::HS_PLUS : atipd_pkg::HS_DATA;
               end else if (!digits_done && c >= atipd_pkg::CH_ZERO
                            && c <= atipd_pkg::CH_NINE) begin
                  acc     = len_acc * 10 + (c - atipd_pkg::CH_ZERO);
                  len_acc = (acc > atipd_pkg::MAX_LEN_DEF)
                          ? atipd_pkg::FRAME_LEN_W'(atipd_pkg::MAX_LEN_DEF)
                          : atipd_pkg::FRAME_LEN_W'(acc);
               end else begin
                  digits_done = 1'b1;
               end
            end
            atipd_pkg::HS_DATA: begin
               r.payload_valid = 1'b1;
               r.payload_byte  = c;
               data_count      = data_count + 1'b1;
               if (data_count >= len_acc) begin
                  r.payload_last = 1'b1;
                  data_count     = '0;
                  hdr_state      = atipd_pkg::HS_PLUS;
               end
            end
            default:
               hdr_state = (c == atipd_pkg::CH_PLUS) ? atipd_pkg::HS_I : atipd_pkg::HS_PLUS;
         endcase

         if (c == atipd_pkg::CH_PROMPT) ready_seen = 1'b1;
         if (!ready_seen) begin
            if (!want_k) begin
               if (c == atipd_pkg::CH_O) want_k = 1'b1;
            end else begin
               want_k = 1'b0;
               if (c == atipd_pkg::CH_K) ready_seen = 1'b1;
            end
         end
      end
      r.frame_length = len_acc;
      r.ready_res    = ready_seen;
      return r;
   endfunction

   task automatic check_field(input string name, input int unsigned want_v,
                              input int unsigned got_v);
      if (want_v != got_v) begin
         $error("%s: expected %0d, actual %0d", name, want_v, got_v);
         mismatch_count++;
      end
   endtask

   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(0, 99) >= rx_stall_pct);
   end

   always @(posedge clock) begin
      parse_result_type want;
      typed_result_type typed;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (expected_q.size() == 0) begin
               $error("result transfer with no expected result pending");
               mismatch_count++;
            end else begin
               want = expected_q.pop_front();
               check_field("payload_valid", want.payload_valid, rsp_payload_valid);
               check_field("payload_byte", want.payload_byte, rsp_payload_byte);
               check_field("payload_last", want.payload_last, rsp_payload_last);
               check_field("frame_length", want.frame_length, rsp_frame_length);
               check_field("brace_valid", want.brace_valid, rsp_brace_valid);
               check_field("brace_byte", want.brace_byte, rsp_brace_byte);
               check_field("brace_last", want.brace_last, rsp_brace_last);
               check_field("ready_res", want.ready_res, rsp_ready_res);
            end
         end
         if (req_valid && req_ready) begin
            want = advance_parser(req_command, req_rx_byte);
            if (typed_q.size() != 0) begin
               typed = typed_q.pop_front();
               if (typed.fixed) want = typed.res;
            end
            expected_q.push_back(want);
         end
      end
   end

   // present one item and hold it until the transfer
   task automatic send_item(input logic cmd, input logic [7:0] chr, input logic fixed,
                            input parse_result_type res);
      typed_result_type typed;
      while ($urandom_range(0, 99) < tx_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      typed.fixed = fixed;
      typed.res   = res;
      typed_q.push_back(typed);
      req_valid   <= 1'b1;
      req_command <= cmd;
      req_rx_byte <= chr;
      items_sent++;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic send_byte(input logic [7:0] chr);
      send_item(atipd_pkg::CMD_BYTE, chr, 1'b0, NO_RES);
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) send_byte(s[i]);
   endtask

   function automatic logic [7:0] pick_char();
      if ($urandom_range(0, 3) == 0) return SPECIALS[$urandom_range(0, 7)];
      return 8'($urandom_range(0, 255));
   endfunction

   task automatic send_frame(input string len_text, input int unsigned count);
      send_text("+IPD,");
      send_text(len_text);
      send_byte(atipd_pkg::CH_COLON);
      for (int unsigned i = 0; i < count; i++) send_byte(pick_char());
   endtask

   task automatic send_random_sequence();
      int unsigned len;
      int unsigned n;
      string       txt;
      string       hdr;
      logic [7:0]  c;
      case ($urandom_range(0, 9))
         0, 1, 2, 3: begin
            len = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
            txt = $sformatf("%0d", len);
            if ($urandom_range(0, 3) == 0) txt = {"0", txt};
            // digits after the first non-digit are ignored
            if ($urandom_range(0, 4) == 0) txt = {txt, ",7"};
            send_frame(txt, len);
         end
         4: begin
            send_byte(atipd_pkg::CH_LBRACE);
            n = $urandom_range(0, 8);
            for (int unsigned i = 0; i < n; i++) begin
               c = pick_char();
               send_byte((c == atipd_pkg::CH_RBRACE) ? atipd_pkg::CH_LBRACE : c);
            end
            send_byte(atipd_pkg::CH_RBRACE);
         end
         5: begin
            if ($urandom_range(0, 1) == 0) send_text("OK\r\n");
            else send_text("> ");
            if ($urandom_range(0, 1) == 0) send_item(atipd_pkg::CMD_ARM,
                                                      8'($urandom_range(0, 255)),
                                                      1'b0, NO_RES);
         end
         6: send_item(atipd_pkg::CMD_ARM, 8'($urandom_range(0, 255)), 1'b0, NO_RES);
         7: begin
            // zero length, plain or with ignored digits after a comma behind it
            if ($urandom_range(0, 1) == 0) send_frame("0", 0);
            else send_frame("0,5", 0);
         end
         8: begin
            hdr = "+IPD,";
            n = $urandom_range(1, 4);
            for (int unsigned i = 0; i < n; i++) send_byte(hdr[i]);
            c = 8'($urandom_range(0, 255));
            send_byte((c == hdr[n]) ? atipd_pkg::CH_COLON : c);
         end
         default: begin
            n = $urandom_range(1, 6);
            for (int unsigned i = 0; i < n; i++) send_byte(8'($urandom_range(0, 255)));
         end
      endcase
   endtask

   initial begin
      int unsigned start_count;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < DIR_ROWS; i++) begin
         send_item(DIRECTED[i].cmd, DIRECTED[i].chr, DIRECTED[i].fixed, DIRECTED[i].res);
      end

      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin tx_idle_pct = 15; rx_stall_pct = 61; end
            1: begin tx_idle_pct = 61; rx_stall_pct = 15; end
            default: begin tx_idle_pct = 0; rx_stall_pct = 0; end
         endcase
         start_count = items_sent;
         while (items_sent - start_count < 360) send_random_sequence();
      end

      // one oversized frame: the length saturates, only its first payload bytes are sent
      send_frame("99999", 24);
      send_random_sequence();

      req_valid <= 1'b0;
      while (expected_q.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   initial begin
      #5ms;
      $display("Mismatches found");
      $finish;
   end

endmodule

### filelist.f
src/atipd_pkg.sv
src/atipd_header.sv
src/at_response_ipd_parser_core.sv
sim/tb_at_response_ipd_parser_core.sv
